FILE: rtl/sefq_pkg.sv
package sefq_pkg;

  localparam int QUEUE_SLOTS_DEF = 8;
  localparam int FRAME_MAX_DEF   = 32;

  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_EOT = 8'h04;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [2:0] {
    STAT_BYTE   = 3'd0,
    STAT_QUEUED = 3'd1,
    STAT_FULL   = 3'd2,
    STAT_BADLEN = 3'd3,
    STAT_EMPTY  = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } state_t;

endpackage

FILE: rtl/soh_eot_frame_queue.sv
// Pushes go one per cycle while in_tready is high; an EOT gives its status the next cycle.
// A pop of an empty ring gives its status word in the cycle after acceptance.
// A pop of a frame gives its first byte via the store's read register and the output
// register, then one byte per cycle while out_tready is high, blocking the input meanwhile.
// Reset (rst_n low, synchronous) clears the ring pointers, assembly count and ignore flag;
// the frame and length memories are not cleared and need no clearing pass.
module soh_eot_frame_queue #(
  parameter int QUEUE_SLOTS = sefq_pkg::QUEUE_SLOTS_DEF,
  parameter int FRAME_MAX   = sefq_pkg::FRAME_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // rx_byte [7:0], packet_start [8], zero [15:9]
  input  logic [0:0]  in_tuser,  // op [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata, // frame_byte [7:0]
  output logic [2:0]  out_tuser, // status [2:0]
  output logic        out_tlast
);
  import sefq_pkg::*;

  localparam int SW = $clog2(QUEUE_SLOTS);
  localparam int IW = (FRAME_MAX > 2) ? $clog2(FRAME_MAX - 1) : 1;
  localparam int LW = $clog2(FRAME_MAX);
  localparam int CW = $clog2(FRAME_MAX + 1);

  state_t        state_r, state_nxt;
  logic [SW-1:0] head_r, head_nxt;
  logic [SW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ignore_r, ignore_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;

  logic          in_acc, out_free, ring_empty, pop_go, stream_done, byte_last;
  logic [SW-1:0] head_inc, tail_inc;
  logic [7:0]    rx_byte;
  logic          packet_start, op;
  logic          byte_we, len_we;
  logic [7:0]    byte_q;
  logic [LW-1:0] len_q;

  assign rx_byte      = in_tdata[7:0];
  assign packet_start = in_tdata[8];
  assign op           = in_tuser[0];

  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign ring_empty = (head_r == tail_r);
  assign head_inc   = (head_r == SW'(QUEUE_SLOTS - 1)) ? '0 : head_r + SW'(1);
  assign tail_inc   = (tail_r == SW'(QUEUE_SLOTS - 1)) ? '0 : tail_r + SW'(1);
  assign pop_go     = in_acc && (op == OP_POP) && !ring_empty && (len_q != '0);
  assign byte_last  = ((LW'(rd_idx_r) + LW'(1)) == len_r);
  assign stream_done = (state_r == ST_STREAM) && out_free && byte_last;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_go) begin
          state_nxt = ST_STREAM;
        end
      end
      ST_STREAM: begin
        if (stream_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE:   in_tready = out_free;
      ST_STREAM: in_tready = 1'b0;
      default:   in_tready = 1'b0;
    endcase
  end

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    ignore_nxt     = ignore_r;
    len_nxt        = len_r;
    rd_idx_nxt     = rd_idx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    byte_we        = 1'b0;
    len_we         = 1'b0;

    if (in_acc && (op == OP_POP)) begin
      if (pop_go) begin
        len_nxt    = len_q;
        rd_idx_nxt = '0;
      end else begin
        if (!ring_empty) begin
          head_nxt = head_inc;
        end
        out_valid_nxt  = 1'b1;
        out_status_nxt = STAT_EMPTY;
        out_byte_nxt   = '0;
        out_last_nxt   = 1'b1;
      end
    end else if (in_acc && !(ignore_r && !packet_start)) begin
      ignore_nxt = 1'b0;
      if (rx_byte == BYTE_NUL) begin
        ignore_nxt = 1'b1;
      end else if (rx_byte == BYTE_SOH) begin
        count_nxt = '0;
      end else if (rx_byte == BYTE_EOT) begin
        if ((count_r != '0) && (count_r < CW'(FRAME_MAX))) begin
          if (tail_inc != head_r) begin
            len_we         = 1'b1;
            tail_nxt       = tail_inc;
            out_status_nxt = STAT_QUEUED;
          end else begin
            out_status_nxt = STAT_FULL;
          end
        end else begin
          out_status_nxt = STAT_BADLEN;
        end
        count_nxt     = '0;
        out_valid_nxt = 1'b1;
        out_byte_nxt  = '0;
        out_last_nxt  = 1'b1;
      end else begin
        if (count_r < CW'(FRAME_MAX - 1)) begin
          byte_we = 1'b1;
        end
        if (count_r < CW'(FRAME_MAX)) begin
          count_nxt = count_r + CW'(1);
        end
      end
    end

    if ((state_r == ST_STREAM) && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = STAT_BYTE;
      out_byte_nxt   = byte_q;
      out_last_nxt   = byte_last;
      rd_idx_nxt     = rd_idx_r + IW'(1);
      if (byte_last) begin
        head_nxt = head_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      ignore_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      ignore_r    <= ignore_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r        <= len_nxt;
    rd_idx_r     <= rd_idx_nxt;
    out_status_r <= out_status_nxt;
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
  end

  sefq_store #(
    .QUEUE_SLOTS(QUEUE_SLOTS),
    .FRAME_MAX  (FRAME_MAX)
  ) u_store (
    .clk       (clk),
    .byte_we   (byte_we),
    .byte_wslot(tail_r),
    .byte_widx (count_r[IW-1:0]),
    .byte_wdata(rx_byte),
    .byte_rslot(head_nxt),
    .byte_ridx (rd_idx_nxt),
    .byte_q    (byte_q),
    .len_we    (len_we),
    .len_waddr (tail_r),
    .len_wdata (count_r[LW-1:0]),
    .len_raddr (head_nxt),
    .len_q     (len_q)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  a_stream_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STREAM) |-> !in_tready)
    else $error("input accepted while a frame is streamed");

  a_ring_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r < SW'(QUEUE_SLOTS - 1)) || (head_r == SW'(QUEUE_SLOTS - 1)))
    else $error("head pointer outside the ring");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r < CW'(FRAME_MAX)) || (count_r == CW'(FRAME_MAX)))
    else $error("assembly count beyond its saturation value");

  a_stream_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STREAM) |-> ((LW'(rd_idx_r) < len_r) && (head_r != tail_r)))
    else $error("stream index beyond the frame length");

  a_queue_advances_tail: assert property (@(posedge clk) disable iff (!rst_n)
    len_we |=> (tail_r != $past(tail_r)))
    else $error("frame queued without the tail moving on");

endmodule

FILE: rtl/sefq_store.sv
module sefq_store #(
  parameter int QUEUE_SLOTS = sefq_pkg::QUEUE_SLOTS_DEF,
  parameter int FRAME_MAX   = sefq_pkg::FRAME_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              byte_we,
  input  logic [$clog2(QUEUE_SLOTS)-1:0]    byte_wslot,
  input  logic [((FRAME_MAX > 2) ? $clog2(FRAME_MAX-1) : 1)-1:0] byte_widx,
  input  logic [7:0]                        byte_wdata,
  input  logic [$clog2(QUEUE_SLOTS)-1:0]    byte_rslot,
  input  logic [((FRAME_MAX > 2) ? $clog2(FRAME_MAX-1) : 1)-1:0] byte_ridx,
  output logic [7:0]                        byte_q,
  input  logic                              len_we,
  input  logic [$clog2(QUEUE_SLOTS)-1:0]    len_waddr,
  input  logic [$clog2(FRAME_MAX)-1:0]      len_wdata,
  input  logic [$clog2(QUEUE_SLOTS)-1:0]    len_raddr,
  output logic [$clog2(FRAME_MAX)-1:0]      len_q
);
  import sefq_pkg::*;

  localparam int SW    = $clog2(QUEUE_SLOTS);
  localparam int IW    = (FRAME_MAX > 2) ? $clog2(FRAME_MAX - 1) : 1;
  localparam int LW    = $clog2(FRAME_MAX);
  localparam int DEPTH = QUEUE_SLOTS * (2 ** IW);

  logic [7:0]    frame_mem [DEPTH];
  logic [LW-1:0] len_mem   [QUEUE_SLOTS];
  logic [7:0]    byte_q_r;
  logic [LW-1:0] len_q_r;

  always_ff @(posedge clk) begin
    if (byte_we) begin
      frame_mem[{byte_wslot, byte_widx}] <= byte_wdata;
    end
    byte_q_r <= frame_mem[{byte_rslot, byte_ridx}];
  end

  // The length of a frame queued into an empty ring is read in the very next cycle,
  // so a write to the address being read is passed straight through.
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    if (len_we && (len_waddr == len_raddr)) begin
      len_q_r <= len_wdata;
    end else begin
      len_q_r <= len_mem[len_raddr];
    end
  end

  assign byte_q = byte_q_r;
  assign len_q  = len_q_r;

endmodule
